// ----- rtl/core/imrc_pkg.sv -----
package imrc_pkg;

    typedef enum logic [1:0] {
        OP_SETUP    = 2'd0,
        OP_TEARDOWN = 2'd1,
        OP_WRITE    = 2'd2,
        OP_DOORBELL = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BAD_SLOT  = 3'd1,
        STS_ACTIVE    = 3'd2,
        STS_INACTIVE  = 3'd3,
        STS_TAIL_BIG  = 3'd4,
        STS_SHORT_HDR = 3'd5,
        STS_BAD_LEN   = 3'd6,
        STS_RSVD      = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_DATA    = 3'd1,
        K_NOTIFY  = 3'd2,
        K_STATUS  = 3'd3,
        K_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_CLR_ALL,
        S_IDLE,
        S_DECODE,
        S_CLR_SLOT,
        S_SETUP_DONE,
        S_LOOP,
        S_HDR,
        S_ALIGN,
        S_MSG
    } t_state;

    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_DATA_CODE   = 2'd0;
    localparam logic [1:0] REG_NOTIFY_CODE = 2'd1;
    localparam logic [1:0] REG_STATUS_CODE = 2'd2;

    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 6;
    localparam logic [2:0] SLOT_NONE = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  slot;
        logic [6:0]  word_index;
        logic [63:0] word_value;
        logic [11:0] doorbell_offset;
        logic [31:0] doorbell_value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  slot_out;
        logic [2:0]  status;
        logic [2:0]  kind;
        logic [9:0]  msg_length;
        logic [9:0]  payload_bytes;
        logic [9:0]  head_after;
        logic [31:0] data_messages_total;
        logic [31:0] data_bytes_total;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] data_code;
        logic [15:0] notify_code;
        logic [15:0] status_code;
    } t_cfg;

endpackage

// ----- rtl/core/imrc_cfg.sv -----
module imrc_cfg
    import imrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_code   <= 16'd1;
            r_cfg.notify_code <= 16'd2;
            r_cfg.status_code <= 16'd3;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_DATA_CODE:   r_cfg.data_code   <= pwdata[15:0];
                REG_NOTIFY_CODE: r_cfg.notify_code <= pwdata[15:0];
                REG_STATUS_CODE: r_cfg.status_code <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DATA_CODE:   prdata = {16'd0, r_cfg.data_code};
            REG_NOTIFY_CODE: prdata = {16'd0, r_cfg.notify_code};
            REG_STATUS_CODE: prdata = {16'd0, r_cfg.status_code};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/imrc_ram.sv -----
module imrc_ram #(
    parameter int DEPTH = 896,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/inbound_message_ring_consumer.sv -----
// Setup, teardown and word writes: the accepted beat is decoded in S_DECODE, which
// registers the result once the output is free; setup first clears the slot ring in
// S_CLR_SLOT and emits from S_SETUP_DONE. Doorbell: each message result follows a
// header fetch, one byte per cycle through a single RAM read port once its word is read,
// and S_ALIGN; output stalls hold the walk. Reset (synchronous, active low) clears all
// slot state, then the ring RAM is swept to zero, one word per cycle, before input.
module inbound_message_ring_consumer
    import imrc_pkg::*;
#(
    parameter int SLOTS           = 7,
    parameter int RING_BYTES      = 1024,
    parameter int HEADER_BYTES    = 16,
    parameter int LENGTH_ALIGN    = 8,
    parameter int DOORBELL_STRIDE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_beat,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int WORDS  = (RING_BYTES + 7) / 8;
    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int WI_W   = PTR_W - 3;
    localparam int DEPTH  = SLOTS * WORDS;
    localparam int MA_W   = $clog2(DEPTH);
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_SH = 16 + $clog2(LENGTH_ALIGN);
    localparam logic [17:0] LEN_M =
        18'(((1 << LEN_SH) + LENGTH_ALIGN - 1) / LENGTH_ALIGN);
    localparam int DB_SH  = 12 + $clog2(DOORBELL_STRIDE);
    localparam logic [13:0] DB_M =
        14'(((1 << DB_SH) + DOORBELL_STRIDE - 1) / DOORBELL_STRIDE);

    t_cfg cfg;

    imrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic            ram_we;
    logic [MA_W-1:0] ram_waddr;
    logic [63:0]     ram_wdata;
    logic            ram_re;
    logic [MA_W-1:0] ram_raddr;
    logic [63:0]     ram_rdata;

    imrc_ram #(.DEPTH(DEPTH), .AW(MA_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    t_state               r_state, n_state;
    t_in_beat             r_in, n_in;
    logic [11:0]          r_dbq, n_dbq;
    logic [SW-1:0]        r_slot, n_slot;
    logic [MA_W-1:0]      r_base, n_base;
    logic [MA_W-1:0]      r_caddr, n_caddr;
    logic [MA_W-1:0]      r_cend, n_cend;
    logic [PTR_W-1:0]     r_head [SLOTS];
    logic [PTR_W-1:0]     n_head [SLOTS];
    logic [PTR_W-1:0]     r_tail [SLOTS];
    logic [PTR_W-1:0]     n_tail [SLOTS];
    logic [SLOTS-1:0]     r_active, n_active;
    logic [PTR_W-1:0]     r_pos, n_pos;
    logic [PTR_W-1:0]     r_avail, n_avail;
    logic [2:0]           r_bi, n_bi;
    logic                 r_cache_ok, n_cache_ok;
    logic [WI_W-1:0]      r_cache_addr, n_cache_addr;
    logic [15:0]          r_type, n_type;
    logic [31:0]          r_len, n_len;
    logic [15:0]          r_q, n_q;
    logic [RES_CNT_W-1:0] r_nres, n_nres;
    logic [31:0]          r_msgs, n_msgs;
    logic [31:0]          r_bytes, n_bytes;
    t_out_beat            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    // datapath helpers
    logic             in_slot_ok, db_ok, db_sub_zero, tail_ok, o_free;
    logic [SW-1:0]    s_idx, ds_idx;
    logic [MA_W-1:0]  s_base;
    logic [25:0]      db_prod, db_shift;
    logic [33:0]      len_prod, len_shift;
    logic [PTR_W-1:0] cur_h, cur_t, pos_next;
    logic [31:0]      avail32, hsum, pay;
    logic [WI_W-1:0]  pos_word;
    logic [7:0]       byte_v;
    logic             len_bad;
    logic [PTR_W-1:0] new_head;
    t_kind            msg_kind;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_free      = !r_out_valid || i_out_ready;

    assign in_slot_ok  = 32'(r_in.slot) < 32'(SLOTS);
    assign s_idx       = SW'(r_in.slot);
    assign s_base      = MA_W'(32'(s_idx) * 32'(WORDS));
    assign db_prod     = 26'(i_in_beat.doorbell_offset) * 26'(DB_M);
    assign db_shift    = db_prod >> DB_SH;
    assign db_ok       = 32'(r_dbq) < 32'(SLOTS);
    assign ds_idx      = SW'(r_dbq);
    assign db_sub_zero = r_in.doorbell_offset == 12'(32'(r_dbq) * 32'(DOORBELL_STRIDE));
    assign tail_ok     = r_in.doorbell_value < 32'(RING_BYTES);

    assign cur_h    = r_head[r_slot];
    assign cur_t    = r_tail[r_slot];
    assign avail32  = (cur_t >= cur_h) ? 32'(cur_t) - 32'(cur_h)
                                       : 32'(RING_BYTES) - 32'(cur_h) + 32'(cur_t);
    assign pos_word = r_pos[PTR_W-1:3];
    assign byte_v   = ram_rdata[{r_pos[2:0], 3'b000} +: 8];
    assign pos_next = (32'(r_pos) + 32'd1 == 32'(RING_BYTES)) ? '0 : r_pos + 1'b1;

    assign len_prod  = 34'(r_len[15:0]) * 34'(LEN_M);
    assign len_shift = len_prod >> LEN_SH;
    assign len_bad   = (r_len < 32'(HEADER_BYTES)) || (r_len > 32'(r_avail))
                       || (32'(r_len[15:0]) != 32'(r_q) * 32'(LENGTH_ALIGN));
    assign hsum      = 32'(cur_h) + r_len;
    assign new_head  = (hsum >= 32'(RING_BYTES)) ? PTR_W'(hsum - 32'(RING_BYTES))
                                                 : PTR_W'(hsum);
    assign pay       = r_len - 32'(HEADER_BYTES);

    always_comb begin
        priority if (r_type == cfg.data_code)   msg_kind = K_DATA;
        else if     (r_type == cfg.notify_code) msg_kind = K_NOTIFY;
        else if     (r_type == cfg.status_code) msg_kind = K_STATUS;
        else                                    msg_kind = K_UNKNOWN;
    end

    logic             emit;
    logic [2:0]       e_slot;
    t_status          e_status;
    t_kind            e_kind;
    logic [31:0]      e_len;
    logic [31:0]      e_pay;
    logic [PTR_W-1:0] e_head;
    logic             e_last;
    logic             msg_last;

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_dbq        = r_dbq;
        n_slot       = r_slot;
        n_base       = r_base;
        n_caddr      = r_caddr;
        n_cend       = r_cend;
        n_head       = r_head;
        n_tail       = r_tail;
        n_active     = r_active;
        n_pos        = r_pos;
        n_avail      = r_avail;
        n_bi         = r_bi;
        n_cache_ok   = r_cache_ok;
        n_cache_addr = r_cache_addr;
        n_type       = r_type;
        n_len        = r_len;
        n_q          = r_q;
        n_nres       = r_nres;
        n_msgs       = r_msgs;
        n_bytes      = r_bytes;
        ram_we       = 1'b0;
        ram_waddr    = r_caddr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_base + MA_W'(pos_word);
        emit         = 1'b0;
        e_slot       = 3'(r_slot);
        e_status     = STS_OK;
        e_kind       = K_NONE;
        e_len        = '0;
        e_pay        = '0;
        e_head       = cur_h;
        e_last       = 1'b1;
        msg_last     = (new_head == cur_t) || (r_nres == RES_CNT_W'(MAX_RESULTS - 1));

        unique case (r_state)
            S_CLR_ALL, S_CLR_SLOT: begin
                ram_we  = 1'b1;
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == r_cend) begin
                    n_state = (r_state == S_CLR_ALL) ? S_IDLE : S_SETUP_DONE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_beat;
                    n_dbq   = db_shift[11:0];
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (o_free) begin
                    n_state = S_IDLE;
                    unique case (r_in.op)
                        OP_DOORBELL: begin
                            e_slot = 3'(r_dbq);
                            e_head = r_head[ds_idx];
                            priority if (!db_ok) begin
                                emit     = 1'b1;
                                e_slot   = SLOT_NONE;
                                e_status = STS_BAD_SLOT;
                                e_head   = '0;
                            end else if (!r_active[ds_idx]) begin
                                emit     = 1'b1;
                                e_status = STS_INACTIVE;
                            end else if (!db_sub_zero) begin
                                emit     = 1'b1;
                                e_status = STS_RSVD;
                            end else if (!tail_ok) begin
                                emit     = 1'b1;
                                e_status = STS_TAIL_BIG;
                            end else begin
                                n_tail[ds_idx] = PTR_W'(r_in.doorbell_value);
                                n_slot         = ds_idx;
                                n_base         = MA_W'(32'(ds_idx) * 32'(WORDS));
                                n_nres         = '0;
                                n_state        = S_LOOP;
                            end
                        end
                        OP_SETUP, OP_TEARDOWN, OP_WRITE: begin
                            e_slot = r_in.slot;
                            e_head = r_head[s_idx];
                            if (!in_slot_ok) begin
                                emit     = 1'b1;
                                e_slot   = SLOT_NONE;
                                e_status = STS_BAD_SLOT;
                                e_head   = '0;
                            end else if (r_in.op == OP_SETUP) begin
                                if (r_active[s_idx]) begin
                                    emit     = 1'b1;
                                    e_status = STS_ACTIVE;
                                end else begin
                                    n_slot  = s_idx;
                                    n_caddr = s_base;
                                    n_cend  = s_base + MA_W'(WORDS - 1);
                                    n_state = S_CLR_SLOT;
                                end
                            end else if (r_in.op == OP_TEARDOWN) begin
                                emit = 1'b1;
                                if (r_active[s_idx]) begin
                                    n_active[s_idx] = 1'b0;
                                end else begin
                                    e_status = STS_INACTIVE;
                                end
                            end else begin
                                emit = 1'b1;
                                if (32'(r_in.word_index) < 32'(WORDS)) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = s_base + MA_W'(r_in.word_index);
                                    ram_wdata = r_in.word_value;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP_DONE: begin
                if (o_free) begin
                    n_head[r_slot]   = '0;
                    n_tail[r_slot]   = '0;
                    n_active[r_slot] = 1'b1;
                    emit             = 1'b1;
                    e_head           = '0;
                    n_state          = S_IDLE;
                end
            end
            S_LOOP: begin
                if (o_free) begin
                    priority if (cur_h == cur_t) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end else if (avail32 < 32'(HEADER_BYTES)) begin
                        emit     = 1'b1;
                        e_status = STS_SHORT_HDR;
                        n_state  = S_IDLE;
                    end else begin
                        n_pos      = cur_h;
                        n_bi       = '0;
                        n_cache_ok = 1'b0;
                        n_avail    = PTR_W'(avail32);
                        n_state    = S_HDR;
                    end
                end
            end
            S_HDR: begin
                if (r_cache_ok && (r_cache_addr == pos_word)) begin
                    unique case (r_bi)
                        3'd0:       n_type[7:0]   = byte_v;
                        3'd1:       n_type[15:8]  = byte_v;
                        3'd2, 3'd3: ;
                        3'd4:       n_len[7:0]    = byte_v;
                        3'd5:       n_len[15:8]   = byte_v;
                        3'd6:       n_len[23:16]  = byte_v;
                        3'd7:       n_len[31:24]  = byte_v;
                        default: ;
                    endcase
                    n_pos = pos_next;
                    n_bi  = r_bi + 1'b1;
                    if (r_bi == 3'd7) begin
                        n_state = S_ALIGN;
                    end
                end else begin
                    ram_re       = 1'b1;
                    n_cache_addr = pos_word;
                    n_cache_ok   = 1'b1;
                end
            end
            S_ALIGN: begin
                n_q     = len_shift[15:0];
                n_state = S_MSG;
            end
            S_MSG: begin
                if (o_free) begin
                    emit = 1'b1;
                    if (len_bad) begin
                        e_status = STS_BAD_LEN;
                        n_state  = S_IDLE;
                    end else begin
                        e_kind = msg_kind;
                        e_len  = r_len;
                        if (msg_kind == K_DATA) begin
                            e_pay   = pay;
                            n_msgs  = r_msgs + 32'd1;
                            n_bytes = r_bytes + pay;
                        end
                        n_head[r_slot] = new_head;
                        e_head         = new_head;
                        e_last         = msg_last;
                        n_nres         = r_nres + 1'b1;
                        n_state        = msg_last ? S_IDLE : S_LOOP;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid               = 1'b1;
            n_out.slot_out            = e_slot;
            n_out.status              = e_status;
            n_out.kind                = e_kind;
            n_out.msg_length          = e_len[9:0];
            n_out.payload_bytes       = e_pay[9:0];
            n_out.head_after          = 10'(e_head);
            n_out.data_messages_total = n_msgs;
            n_out.data_bytes_total    = n_bytes;
            n_out.last                = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_ALL;
            r_caddr     <= '0;
            r_cend      <= MA_W'(DEPTH - 1);
            r_active    <= '0;
            r_cache_ok  <= 1'b0;
            r_nres      <= '0;
            r_msgs      <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_caddr     <= n_caddr;
            r_cend      <= n_cend;
            r_active    <= n_active;
            r_cache_ok  <= n_cache_ok;
            r_nres      <= n_nres;
            r_msgs      <= n_msgs;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_dbq        <= n_dbq;
        r_slot       <= n_slot;
        r_base       <= n_base;
        r_pos        <= n_pos;
        r_avail      <= n_avail;
        r_bi         <= n_bi;
        r_cache_addr <= n_cache_addr;
        r_type       <= n_type;
        r_len        <= n_len;
        r_q          <= n_q;
        r_out        <= n_out;
    end

`ifndef SYNTHESIS
    // a non-final result means the walk over the ring is still going
    a_stream_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == S_LOOP || r_state == S_HDR
            || r_state == S_ALIGN || r_state == S_MSG))
        else $error("non-final result outside message walk");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |-> (32'(r_pos) < 32'(RING_BYTES)))
        else $error("header byte position beyond ring");

    a_loop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP && r_nres != '0) |-> (r_head[r_slot] != r_tail[r_slot]))
        else $error("walk continued on an empty ring");

    a_msg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MSG) |-> ($past(r_state) == S_ALIGN || $past(r_state) == S_MSG))
        else $error("message check without alignment step");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
    import imrc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_in_beat  b;
        bit        typed;
        t_out_beat e;
    } t_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in_beat        i_in_beat;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out_beat       o_out_beat;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    inbound_message_ring_consumer u_dut (.*);

    // mirror of the ring state
    logic [63:0] ring_mem [0:895];
    logic [9:0]  head_q [0:6];
    logic [9:0]  tail_q [0:6];
    bit          live [0:6];
    logic [31:0] data_msgs;
    logic [31:0] data_bytes;
    logic [15:0] code_data;
    logic [15:0] code_notify;
    logic [15:0] code_status;

    t_out_beat   results_due[$];
    t_row        rows[$];
    int          errors;
    int          idle_cycles;
    int          items;
    int          snd_idle;
    int          rcv_stall;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_in_beat beat(t_op op, logic [2:0] sl, logic [6:0] wi,
                                      logic [63:0] wv, logic [11:0] off,
                                      logic [31:0] val);
        t_in_beat b;
        b.op = op;
        b.slot = sl;
        b.word_index = wi;
        b.word_value = wv;
        b.doorbell_offset = off;
        b.doorbell_value = val;
        return b;
    endfunction

    function automatic t_out_beat rsp(logic [2:0] sl, t_status st, logic [9:0] hd);
        t_out_beat r;
        r = '0;
        r.slot_out = sl;
        r.status = st;
        r.kind = K_NONE;
        r.head_after = hd;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [63:0] hdr(logic [15:0] typ, logic [31:0] len);
        return {len, 16'($urandom), typ};
    endfunction

    function automatic logic [7:0] ring_byte(int s, int pos);
        int b;
        b = pos % 1024;
        return 8'(ring_mem[s * 128 + b / 8] >> ((b % 8) * 8));
    endfunction

    task automatic add_result(int sl, t_status st, t_kind kd, longint len, longint pay,
                              int hd, bit last);
        t_out_beat r;
        r.slot_out = 3'(sl);
        r.status = st;
        r.kind = kd;
        r.msg_length = 10'(len);
        r.payload_bytes = 10'(pay);
        r.head_after = 10'(hd);
        r.data_messages_total = data_msgs;
        r.data_bytes_total = data_bytes;
        r.last = last;
        results_due.push_back(r);
    endtask

    task automatic drain_ring(int s);
        int n;
        int h;
        int t;
        int avail;
        longint len;
        logic [15:0] typ;
        t_kind kd;
        longint pay;
        n = 0;
        while (head_q[s] != tail_q[s] && n < MAX_RESULTS) begin
            h = head_q[s];
            t = tail_q[s];
            avail = (t >= h) ? t - h : 1024 - h + t;
            if (avail < 16) begin
                add_result(s, STS_SHORT_HDR, K_NONE, 0, 0, h, 1);
                return;
            end
            typ = {ring_byte(s, h + 1), ring_byte(s, h)};
            len = {ring_byte(s, h + 7), ring_byte(s, h + 6), ring_byte(s, h + 5),
                   ring_byte(s, h + 4)};
            if (len < 16 || len > avail || (len % 8) != 0) begin
                add_result(s, STS_BAD_LEN, K_NONE, 0, 0, h, 1);
                return;
            end
            pay = 0;
            if (typ == code_data) begin
                kd = K_DATA;
                pay = len - 16;
                data_msgs += 1;
                data_bytes += 32'(pay);
            end else if (typ == code_notify) begin
                kd = K_NOTIFY;
            end else if (typ == code_status) begin
                kd = K_STATUS;
            end else begin
                kd = K_UNKNOWN;
            end
            head_q[s] = 10'((h + len) % 1024);
            add_result(s, STS_OK, kd, len, pay, head_q[s], 0);
            n++;
        end
        if (n == 0) add_result(s, STS_OK, K_NONE, 0, 0, head_q[s], 1);
        else results_due[results_due.size() - 1].last = 1'b1;
    endtask

    task automatic ring_predict(t_in_beat b);
        int s;
        int ds;
        int sub;
        s = b.slot;
        if (b.op == OP_DOORBELL) begin
            ds = b.doorbell_offset / 8;
            sub = b.doorbell_offset % 8;
            if (ds >= 7) add_result(SLOT_NONE, STS_BAD_SLOT, K_NONE, 0, 0, 0, 1);
            else if (!live[ds]) add_result(ds, STS_INACTIVE, K_NONE, 0, 0, head_q[ds], 1);
            else if (sub != 0) add_result(ds, STS_RSVD, K_NONE, 0, 0, head_q[ds], 1);
            else if (b.doorbell_value >= 1024)
                add_result(ds, STS_TAIL_BIG, K_NONE, 0, 0, head_q[ds], 1);
            else begin
                tail_q[ds] = 10'(b.doorbell_value);
                drain_ring(ds);
            end
        end else if (s >= 7) begin
            add_result(SLOT_NONE, STS_BAD_SLOT, K_NONE, 0, 0, 0, 1);
        end else if (b.op == OP_SETUP) begin
            if (live[s]) add_result(s, STS_ACTIVE, K_NONE, 0, 0, head_q[s], 1);
            else begin
                for (int i = 0; i < 128; i++) ring_mem[s * 128 + i] = '0;
                head_q[s] = '0;
                tail_q[s] = '0;
                live[s] = 1;
                add_result(s, STS_OK, K_NONE, 0, 0, 0, 1);
            end
        end else if (b.op == OP_TEARDOWN) begin
            if (!live[s]) add_result(s, STS_INACTIVE, K_NONE, 0, 0, head_q[s], 1);
            else begin
                live[s] = 0;
                add_result(s, STS_OK, K_NONE, 0, 0, head_q[s], 1);
            end
        end else begin
            ring_mem[s * 128 + b.word_index] = b.word_value;
            add_result(s, STS_OK, K_NONE, 0, 0, head_q[s], 1);
        end
    endtask

    // typed rows replace the predicted single result
    task automatic send(t_in_beat b, bit typed = 0, t_out_beat e = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_beat = b;
        do @(posedge i_clk); while (!o_in_ready);
        ring_predict(b);
        if (typed) results_due[results_due.size() - 1] = e;
        items++;
    endtask

    task automatic quiesce(int extra);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {16'($urandom), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_DATA_CODE:   code_data = val;
            REG_NOTIFY_CODE: code_notify = val;
            default:         code_status = val;
        endcase
    endtask

    function automatic logic [15:0] pick_type();
        case ($urandom_range(3))
            0: return code_data;
            1: return code_notify;
            2: return code_status;
            default: return 16'($urandom);
        endcase
    endfunction

    // a run of messages (some with a random length) starting at head, then its doorbell
    task automatic message_burst();
        int s;
        int pos;
        int sum;
        int len;
        int n;
        logic [31:0] tail;
        s = $urandom_range(6);
        if (!live[s]) send(beat(OP_SETUP, 3'(s), 0, 0, 0, 0));
        pos = head_q[s];
        sum = 0;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            len = 8 * $urandom_range(2, 12);
            if (sum + len > 1000) break;
            if ($urandom_range(9) == 0) len = $urandom;
            send(beat(OP_WRITE, 3'(s), 7'(pos / 8), hdr(pick_type(), len), 0, 0));
            if ($urandom_range(3) == 0)
                send(beat(OP_WRITE, 3'(s), 7'((pos + 8) % 1024 / 8),
                          {$urandom, $urandom}, 0, 0));
            pos = (pos + (len % 1024)) % 1024;
            sum += len % 1024;
        end
        tail = 32'(pos);
        case ($urandom_range(7))
            0: tail = 32'((pos + 1016) % 1024);
            1: tail = $urandom;
            default: ;
        endcase
        send(beat(OP_DOORBELL, 0, 7'($urandom), {$urandom, $urandom}, 12'(s * 8), tail));
    endtask

    task automatic noise_item();
        send(beat(t_op'($urandom_range(3)), 3'($urandom), 7'($urandom),
                  {$urandom, $urandom}, 12'($urandom), $urandom));
    endtask

    task automatic random_phase(int target);
        int stop_at;
        stop_at = items + target;
        while (items < stop_at) begin
            if ($urandom_range(4) == 0) noise_item();
            else message_burst();
        end
    endtask

    function automatic int chk(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s expected %0h actual %0h", name, e, a);
            return 1;
        end
        return 0;
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge i_clk) begin
        t_out_beat e;
        if (o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("unexpected beat %p", o_out_beat);
                errors++;
            end else begin
                e = results_due.pop_front();
                errors += chk("slot_out", e.slot_out, o_out_beat.slot_out);
                errors += chk("status", e.status, o_out_beat.status);
                errors += chk("kind", e.kind, o_out_beat.kind);
                errors += chk("msg_length", e.msg_length, o_out_beat.msg_length);
                errors += chk("payload_bytes", e.payload_bytes, o_out_beat.payload_bytes);
                errors += chk("head_after", e.head_after, o_out_beat.head_after);
                errors += chk("data_messages_total", e.data_messages_total,
                              o_out_beat.data_messages_total);
                errors += chk("data_bytes_total", e.data_bytes_total,
                              o_out_beat.data_bytes_total);
                errors += chk("last", e.last, o_out_beat.last);
            end
        end
        if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= 20000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        idle_cycles = 0;
        items = 0;
        snd_idle = 32;
        rcv_stall = 59;
        for (int i = 0; i < 896; i++) ring_mem[i] = '0;
        for (int i = 0; i < 7; i++) begin
            head_q[i] = '0;
            tail_q[i] = '0;
            live[i] = 0;
        end
        data_msgs = '0;
        data_bytes = '0;
        code_data = 16'd1;
        code_notify = 16'd2;
        code_status = 16'd3;

        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 0), 1, rsp(0, STS_INACTIVE, 0)});
        rows.push_back('{beat(OP_SETUP, 7, 0, 0, 0, 0), 1, rsp(7, STS_BAD_SLOT, 0)});
        rows.push_back('{beat(OP_TEARDOWN, 7, 0, 0, 0, 0), 1, rsp(7, STS_BAD_SLOT, 0)});
        rows.push_back('{beat(OP_WRITE, 7, 127, '1, 0, 0), 1, rsp(7, STS_BAD_SLOT, 0)});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 12'hFFF, '1), 1,
                         rsp(7, STS_BAD_SLOT, 0)});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 56, 0), 1, rsp(7, STS_BAD_SLOT, 0)});
        rows.push_back('{beat(OP_SETUP, 0, 0, 0, 0, 0), 1, rsp(0, STS_OK, 0)});
        rows.push_back('{beat(OP_SETUP, 0, 0, 0, 0, 0), 1, rsp(0, STS_ACTIVE, 0)});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 7, 0), 1, rsp(0, STS_RSVD, 0)});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 1024), 1, rsp(0, STS_TAIL_BIG, 0)});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, '1), 1, rsp(0, STS_TAIL_BIG, 0)});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 0), 1, rsp(0, STS_OK, 0)});
        rows.push_back('{beat(OP_WRITE, 0, 0, {32'd24, 16'hFFFF, 16'd1}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_WRITE, 0, 3, {32'd16, 16'd0, 16'd2}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_WRITE, 0, 5, {32'd16, 16'd0, 16'd3}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_WRITE, 0, 7, {32'd16, 16'd0, 16'hFFFF}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 72), 0, '0});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 80), 0, '0});
        rows.push_back('{beat(OP_WRITE, 0, 9, {32'd20, 16'd0, 16'd1}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 104), 0, '0});
        rows.push_back('{beat(OP_WRITE, 0, 9, {32'd8, 16'd0, 16'd1}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 104), 0, '0});
        rows.push_back('{beat(OP_WRITE, 0, 9, {32'd40, 16'd0, 16'd1}, 0, 0), 0, '0});
        rows.push_back('{beat(OP_DOORBELL, 0, 0, 0, 0, 104), 0, '0});
        rows.push_back('{beat(OP_TEARDOWN, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{beat(OP_TEARDOWN, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{beat(OP_WRITE, 5, 127, '1, 0, 0), 0, '0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send(rows[i].b, rows[i].typed, rows[i].e);
        quiesce(20);

        cfg_write(REG_DATA_CODE, 16'h0000);
        cfg_write(REG_NOTIFY_CODE, 16'hFFFF);
        cfg_write(REG_STATUS_CODE, 16'h0000);
        random_phase(65);
        quiesce(20);

        snd_idle = 59;
        rcv_stall = 32;
        cfg_write(REG_DATA_CODE, 16'hFFFF);
        cfg_write(REG_NOTIFY_CODE, 16'hFFFF);
        cfg_write(REG_STATUS_CODE, 16'hFFFF);
        random_phase(65);
        quiesce(20);

        snd_idle = 0;
        rcv_stall = 0;
        cfg_write(REG_DATA_CODE, 16'd1);
        cfg_write(REG_NOTIFY_CODE, 16'd2);
        cfg_write(REG_STATUS_CODE, 16'd3);
        random_phase(65);
        quiesce(50);

        if (errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule
